### design/ert_pkg.sv
// ----------------------------------------------------------------------------
// ert_pkg
// Shared types and constants for the echo request tracker: slot layout,
// result status codes and the divide-by-1000 reciprocal.
// ----------------------------------------------------------------------------
package ert_pkg;

	localparam int SEQ_W   = 16;
	localparam int STAMP_W = 32;
	localparam int LEN_W   = 16;
	localparam int RTT_W   = 23;
	localparam int CNT_W   = 16;

	// floor(x / 1000) = (x * ceil(2^38 / 1000)) >> 38, exact for 32-bit x
	localparam int RECIP_W     = 29;
	localparam int RECIP_SHIFT = 38;
	localparam int PROD_W      = STAMP_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

	localparam logic [LEN_W-1:0] MIN_ICMP_LEN = 16'd8;
	localparam logic [7:0]       ECHO_REPLY   = 8'd0;

	localparam logic OP_SEND  = 1'b0;
	localparam logic OP_REPLY = 1'b1;

	localparam logic REG_OWN_ID = 1'b0;

	typedef enum logic [2:0] {
		ST_SENT    = 3'd0,
		ST_FULL    = 3'd1,
		ST_MATCH   = 3'd2,
		ST_SHORT   = 3'd3,
		ST_FOREIGN = 3'd4,
		ST_UNKNOWN = 3'd5
	} status_t;

	typedef struct packed {
		logic               busy;
		logic [SEQ_W-1:0]   seq;
		logic [STAMP_W-1:0] stamp;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

### design/ert_ram.sv
// ----------------------------------------------------------------------------
// ert_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ert_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/ert_div1000.sv
// ----------------------------------------------------------------------------
// ert_div1000
// Microsecond to millisecond converter: multiply by reciprocal, one register
// stage, quotient taken from the upper product bits.
// ----------------------------------------------------------------------------
module ert_div1000
	import ert_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [STAMP_W-1:0] dividend,
	output logic               done,
	output logic [RTT_W-1:0]   quotient
);

	logic [PROD_W-1:0] prod_d;
	logic [PROD_W-1:0] prod_s1;
	logic              done_s1;

	assign prod_d = {{RECIP_W{1'b0}}, dividend} * {{STAMP_W{1'b0}}, RECIP_1000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= prod_d;
		end
	end

	assign done     = done_s1;
	assign quotient = prod_s1[RECIP_SHIFT +: RTT_W];

endmodule

### design/echo_request_tracker.sv
// ----------------------------------------------------------------------------
// echo_request_tracker
// Outstanding echo request table: send transfers claim the first free slot,
// reply transfers are checked, looked up by sequence and timed.
// ----------------------------------------------------------------------------
// channel  | handshake                   | payload
// in       | in_valid / in_ready         | op, now_us, ip_header_words,
//          |                             | total_length, reply_type,
//          |                             | icmp_ident, reply_seq
// out      | out_valid / out_ready       | status, seq_out, rtt_ms,
//          |                             | icmp_length, sent_count, recv_count
// cfg      | psel/penable/pwrite/pready  | paddr, pwdata, prdata (own_id @ 0)
//
// after reset the slot RAM is cleared one entry per cycle with in_ready low;
// apb writes are taken throughout
// a send or a checked reply scans the slot RAM one entry per cycle through its
// read port; a reply match then passes through S_DIV and S_WAIT for the divide
// by 1000; short or foreign replies skip the scan and go straight to S_RESULT
// one transfer in flight at a time; the output register lets the next
// transfer be accepted while a result waits, a finished result waits for it
// ----------------------------------------------------------------------------
module echo_request_tracker
	import ert_pkg::*;
#(
	parameter int TABLE_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [31:0]        now_us,
	input  logic [3:0]         ip_header_words,
	input  logic [15:0]        total_length,
	input  logic [7:0]         reply_type,
	input  logic [15:0]        icmp_ident,
	input  logic [15:0]        reply_seq,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [15:0]        seq_out,
	output logic [22:0]        rtt_ms,
	output logic [15:0]        icmp_length,
	output logic [15:0]        sent_count,
	output logic [15:0]        recv_count,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DIV,
		S_WAIT,
		S_RESULT
	} state_t;

	state_t state_q;

	logic [SEQ_W-1:0]   own_id_q;
	logic [CNT_W-1:0]   send_cnt_q;
	logic [CNT_W-1:0]   recv_cnt_q;

	logic               op_q;
	logic [STAMP_W-1:0] now_q;
	logic [SEQ_W-1:0]   rseq_q;

	logic [AW-1:0]      idx_q;
	logic               issue_done_q;
	logic               rvalid_s1;
	logic [AW-1:0]      ridx_s1;
	logic [STAMP_W-1:0] diff_q;

	status_t            res_status_q;
	logic [SEQ_W-1:0]   res_seq_q;
	logic [RTT_W-1:0]   res_rtt_q;
	logic [LEN_W-1:0]   res_len_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic [SEQ_W-1:0]   out_seq_q;
	logic [RTT_W-1:0]   out_rtt_q;
	logic [LEN_W-1:0]   out_len_q;
	logic [CNT_W-1:0]   out_sent_q;
	logic [CNT_W-1:0]   out_recv_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	slot_t              ram_wdata;
	logic [SLOT_W-1:0]  ram_rdata;
	slot_t              slot_rd;

	logic               in_xfer;
	logic               cfg_wr;
	logic [5:0]         hdr_bytes;
	logic [LEN_W-1:0]   ilen_d;
	logic               short_d;
	logic               foreign_d;
	logic               hit;
	logic               scan_last;
	logic               div_start;
	logic               div_done;
	logic [RTT_W-1:0]   div_q;

	// apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_OWN_ID);
	assign prdata = (paddr[2] == REG_OWN_ID) ? {16'b0, own_id_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
		end else if (cfg_wr) begin
			own_id_q <= pwdata[SEQ_W-1:0];
		end
	end

	// reply checks at accept
	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign hdr_bytes = {ip_header_words, 2'b00};
	assign ilen_d    = (total_length >= {10'b0, hdr_bytes}) ?
		total_length - {10'b0, hdr_bytes} : '0;
	assign short_d   = ilen_d < MIN_ICMP_LEN;
	assign foreign_d = (reply_type != ECHO_REPLY) || (icmp_ident != own_id_q);

	// scan compare
	assign slot_rd   = slot_t'(ram_rdata);
	assign hit       = rvalid_s1 && ((op_q == OP_SEND) ? !slot_rd.busy :
		(slot_rd.busy && (slot_rd.seq == rseq_q)));
	assign scan_last = rvalid_s1 && (ridx_s1 == LAST_IDX);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ridx_s1;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q;
		end else if ((state_q == S_SCAN) && hit) begin
			ram_we = 1'b1;
			if (op_q == OP_SEND) begin
				ram_wdata = '{busy: 1'b1, seq: send_cnt_q, stamp: now_q};
			end else begin
				ram_wdata = '{busy: 1'b0, seq: slot_rd.seq, stamp: slot_rd.stamp};
			end
		end
	end

	ert_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (TABLE_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign div_start = (state_q == S_DIV);

	ert_div1000 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			rvalid_s1    <= 1'b0;
			send_cnt_q   <= '0;
			recv_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						op_q         <= op;
						now_q        <= now_us;
						rseq_q       <= reply_seq;
						idx_q        <= '0;
						issue_done_q <= 1'b0;
						rvalid_s1    <= 1'b0;
						res_rtt_q    <= '0;
						if (op == OP_SEND) begin
							res_seq_q <= send_cnt_q;
							res_len_q <= '0;
							state_q   <= S_SCAN;
						end else begin
							res_seq_q <= reply_seq;
							res_len_q <= ilen_d;
							if (short_d) begin
								res_status_q <= ST_SHORT;
								state_q      <= S_RESULT;
							end else if (foreign_d) begin
								res_status_q <= ST_FOREIGN;
								state_q      <= S_RESULT;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					rvalid_s1 <= !issue_done_q && !hit && !scan_last;
					ridx_s1   <= idx_q;
					if (!issue_done_q) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == LAST_IDX) begin
							issue_done_q <= 1'b1;
						end
					end
					if (hit) begin
						if (op_q == OP_SEND) begin
							send_cnt_q   <= send_cnt_q + 1'b1;
							res_status_q <= ST_SENT;
							state_q      <= S_RESULT;
						end else begin
							diff_q  <= now_q - slot_rd.stamp;
							state_q <= S_DIV;
						end
					end else if (scan_last) begin
						res_status_q <= (op_q == OP_SEND) ? ST_FULL : ST_UNKNOWN;
						state_q      <= S_RESULT;
					end
				end
				S_DIV: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						res_rtt_q    <= div_q;
						res_status_q <= ST_MATCH;
						recv_cnt_q   <= recv_cnt_q + 1'b1;
						state_q      <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_seq_q    <= res_seq_q;
						out_rtt_q    <= res_rtt_q;
						out_len_q    <= res_len_q;
						out_sent_q   <= send_cnt_q;
						out_recv_q   <= recv_cnt_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign seq_out     = out_seq_q;
	assign rtt_ms      = out_rtt_q;
	assign icmp_length = out_len_q;
	assign sent_count  = out_sent_q;
	assign recv_count  = out_recv_q;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for echo_request_tracker. A scoreboard keeps its own
// slot table, counters and identifier register, predicts the result of every
// accepted transfer and checks the result channel in order. Directed
// transfers cover edge cases; random phases then mix well-formed request and
// reply traffic with noise under several idle and stall patterns and
// identifier settings.
// ----------------------------------------------------------------------------
module testbench;
	import ert_pkg::*;

	localparam int TABLE_DEPTH     = 128;
	localparam int SETTLE_CYCLES   = TABLE_DEPTH + 16;
	localparam int QUIET_LIMIT     = 3000;
	localparam int ITEMS_PER_PHASE = 230;
	localparam int NUM_PHASES      = 8;
	localparam int MAX_PRINTED     = 200;
	localparam logic [2:0] OWN_ID_ADDR = 3'(4 * REG_OWN_ID);
	localparam logic [2:0] UNUSED_ADDR = 3'd4;

	typedef struct {
		logic        op;
		logic [31:0] now;
		logic [3:0]  hdr_words;
		logic [15:0] total;
		logic [7:0]  itype;
		logic [15:0] ident;
		logic [15:0] rseq;
	} echo_item_t;

	typedef struct {
		status_t     status;
		logic [15:0] seq;
		logic [22:0] rtt;
		logic [15:0] ilen;
		logic [15:0] sent;
		logic [15:0] recv;
	} echo_result_t;

	class echo_scoreboard;
		bit          slot_busy [TABLE_DEPTH];
		logic [15:0] slot_seq [TABLE_DEPTH];
		logic [31:0] slot_stamp [TABLE_DEPTH];
		logic [15:0] send_cnt;
		logic [15:0] recv_cnt;
		logic [15:0] own_id;
		echo_result_t awaited_results [$];
		int unsigned mismatches;
		int unsigned checked;

		function new();
			foreach (slot_busy[i]) slot_busy[i] = 1'b0;
			send_cnt = '0;
			recv_cnt = '0;
			own_id = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		task report_mismatch(input string msg);
			if (mismatches < MAX_PRINTED)
				$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task compare_field(input string name, input logic [31:0] got,
				input logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d %s got %0d want %0d",
					checked, name, got, want));
		endtask

		function void note_item(input echo_item_t it);
			echo_result_t r;
			logic [17:0] hdr_bytes;
			r.status = ST_FULL;
			r.seq = send_cnt;
			r.rtt = '0;
			r.ilen = '0;
			if (it.op == OP_SEND) begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (!slot_busy[i]) begin
						slot_busy[i] = 1'b1;
						slot_seq[i] = send_cnt;
						slot_stamp[i] = it.now;
						send_cnt = send_cnt + 16'd1;
						r.status = ST_SENT;
						break;
					end
				end
			end else begin
				hdr_bytes = {12'b0, it.hdr_words, 2'b00};
				r.seq = it.rseq;
				r.ilen = ({2'b00, it.total} >= hdr_bytes) ? 16'({2'b00, it.total} - hdr_bytes) : '0;
				if (r.ilen < MIN_ICMP_LEN) begin
					r.status = ST_SHORT;
				end else if (it.itype != ECHO_REPLY || it.ident != own_id) begin
					r.status = ST_FOREIGN;
				end else begin
					r.status = ST_UNKNOWN;
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						if (slot_busy[i] && slot_seq[i] == it.rseq) begin
							slot_busy[i] = 1'b0;
							recv_cnt = recv_cnt + 16'd1;
							r.rtt = 23'((it.now - slot_stamp[i]) / 32'd1000);
							r.status = ST_MATCH;
							break;
						end
					end
				end
			end
			r.sent = send_cnt;
			r.recv = recv_cnt;
			awaited_results.push_back(r);
		endfunction

		task check_result(input logic [2:0] st, input logic [15:0] seq,
				input logic [22:0] rtt, input logic [15:0] ilen,
				input logic [15:0] sent, input logic [15:0] recv);
			echo_result_t e;
			if (awaited_results.size() == 0) begin
				report_mismatch("result transfer with no request outstanding");
				return;
			end
			e = awaited_results.pop_front();
			compare_field("status", 32'(st), 32'(e.status));
			compare_field("seq_out", 32'(seq), 32'(e.seq));
			compare_field("rtt_ms", 32'(rtt), 32'(e.rtt));
			compare_field("icmp_length", 32'(ilen), 32'(e.ilen));
			compare_field("sent_count", 32'(sent), 32'(e.sent));
			compare_field("recv_count", 32'(recv), 32'(e.recv));
			checked++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = 1'b0;
	logic [31:0] now_us = '0;
	logic [3:0]  ip_header_words = '0;
	logic [15:0] total_length = '0;
	logic [7:0]  reply_type = '0;
	logic [15:0] icmp_ident = '0;
	logic [15:0] reply_seq = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [15:0] seq_out;
	logic [22:0] rtt_ms;
	logic [15:0] icmp_length;
	logic [15:0] sent_count;
	logic [15:0] recv_count;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int quiet_cycles = 0;
	echo_scoreboard sb = new();

	echo_request_tracker #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .now_us(now_us),
		.ip_header_words(ip_header_words), .total_length(total_length),
		.reply_type(reply_type), .icmp_ident(icmp_ident), .reply_seq(reply_seq),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.seq_out(seq_out), .rtt_ms(rtt_ms), .icmp_length(icmp_length),
		.sent_count(sent_count), .recv_count(recv_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// result side: check transfers, random stalls, idle watch
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(status, seq_out, rtt_ms, icmp_length, sent_count, recv_count);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	function automatic echo_item_t mk(input logic o, input logic [31:0] t,
			input logic [3:0] hw, input logic [15:0] tl, input logic [7:0] ty,
			input logic [15:0] id, input logic [15:0] sq);
		echo_item_t it;
		it.op = o;
		it.now = t;
		it.hdr_words = hw;
		it.total = tl;
		it.itype = ty;
		it.ident = id;
		it.rseq = sq;
		return it;
	endfunction

	function automatic echo_item_t random_item(input int send_pct);
		echo_item_t it;
		int busy_idx [$];
		int sub;
		int pick;
		int mode;
		logic [17:0] hdr_bytes;
		it = mk(OP_REPLY, $urandom, 4'($urandom_range(15)), 16'($urandom),
			8'($urandom_range(255)), 16'($urandom), 16'($urandom));
		if ($urandom_range(99) < send_pct) begin
			it.op = OP_SEND;
			return it;
		end
		sub = $urandom_range(99);
		if (sub >= 90)
			return it;
		hdr_bytes = {12'b0, it.hdr_words, 2'b00};
		it.itype = ECHO_REPLY;
		it.ident = sb.own_id;
		it.total = 16'(hdr_bytes + 18'd8 + 18'($urandom_range(1500)));
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (sb.slot_busy[i]) busy_idx.push_back(i);
		if (busy_idx.size() > 0) begin
			pick = busy_idx[$urandom_range(busy_idx.size() - 1)];
			it.rseq = sb.slot_seq[pick];
			mode = $urandom_range(9);
			if (mode < 6)
				it.now = sb.slot_stamp[pick] + 32'($urandom_range(3000000));
			else if (mode < 8)
				it.now = sb.slot_stamp[pick] + 32'($urandom_range(999));
		end
		if (sub < 65 && busy_idx.size() > 0) begin
			// well-formed reply to an outstanding request
		end else if (sub < 75) begin
			it.total = 16'($urandom_range(0, hdr_bytes + 7));
		end else if (sub < 83) begin
			if ($urandom_range(1))
				it.itype = 8'($urandom_range(1, 255));
			else
				it.ident = sb.own_id ^ 16'($urandom_range(1, 65535));
		end else begin
			it.rseq = sb.send_cnt + 16'($urandom_range(200));
		end
		return it;
	endfunction

	task automatic put_item(input echo_item_t it);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		op <= it.op;
		now_us <= it.now;
		ip_header_words <= it.hdr_words;
		total_length <= it.total;
		reply_type <= it.itype;
		icmp_ident <= it.ident;
		reply_seq <= it.rseq;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == OWN_ID_ADDR)
			sb.own_id = data[15:0];
	endtask

	initial begin
		logic [15:0] id_setting;
		int send_pct;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, identifier at its reset value until it is set to 16'hFFFF
		put_item(mk(OP_SEND, 32'h0, 4'h0, 16'h0, 8'h00, 16'h0, 16'h0));
		put_item(mk(OP_SEND, 32'hFFFFFFFF, 4'hF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
		put_item(mk(OP_REPLY, 32'd999, 4'd5, 16'd28, ECHO_REPLY, 16'h0, 16'd0));
		put_item(mk(OP_REPLY, 32'd999, 4'd5, 16'd28, ECHO_REPLY, 16'h0, 16'd1));
		put_item(mk(OP_REPLY, 32'd999, 4'd5, 16'd28, ECHO_REPLY, 16'h0, 16'd1));
		put_item(mk(OP_REPLY, 32'd0, 4'hF, 16'd0, ECHO_REPLY, 16'h0, 16'd0));
		put_item(mk(OP_REPLY, 32'd0, 4'h0, 16'd7, ECHO_REPLY, 16'h0, 16'd0));
		put_item(mk(OP_REPLY, 32'd0, 4'h0, 16'hFFFF, 8'hFF, 16'h0, 16'd0));
		put_item(mk(OP_REPLY, 32'd0, 4'hF, 16'hFFFF, ECHO_REPLY, 16'hFFFF, 16'd0));
		put_item(mk(OP_SEND, 32'd5, 4'h0, 16'h0, 8'h00, 16'h0, 16'h0));
		put_item(mk(OP_REPLY, 32'd4, 4'h0, 16'd8, ECHO_REPLY, 16'h0, 16'd2));
		put_item(mk(OP_REPLY, 32'd4, 4'h0, 16'd8, ECHO_REPLY, 16'h0, 16'hFFFF));
		put_item(mk(OP_SEND, 32'd1000, 4'h0, 16'h0, 8'h00, 16'h0, 16'h0));
		put_item(mk(OP_SEND, 32'd2000, 4'h0, 16'h0, 8'h00, 16'h0, 16'h0));
		put_item(mk(OP_REPLY, 32'd1001999, 4'd5, 16'd84, ECHO_REPLY, 16'h0, 16'd4));
		wait_idle();
		cfg_write(UNUSED_ADDR, 32'hFFFFFFFF);
		put_item(mk(OP_REPLY, 32'd2000, 4'd5, 16'd84, ECHO_REPLY, 16'h0, 16'd3));
		wait_idle();
		cfg_write(OWN_ID_ADDR, 32'h0000FFFF);
		put_item(mk(OP_SEND, 32'd123, 4'h0, 16'h0, 8'h00, 16'h0, 16'h0));
		put_item(mk(OP_REPLY, 32'd500, 4'd5, 16'd84, ECHO_REPLY, 16'h0, 16'd5));
		put_item(mk(OP_REPLY, 32'd122, 4'd5, 16'd84, ECHO_REPLY, 16'hFFFF, 16'd5));

		// random phases
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			case (p)
				1: id_setting = 16'h0000;
				2: id_setting = 16'hFFFF;
				4: id_setting = 16'h8000;
				6: id_setting = 16'h0001;
				default: id_setting = 16'($urandom);
			endcase
			cfg_write(OWN_ID_ADDR, {16'($urandom), id_setting});
			case (p % 4)
				0: begin in_idle_pct = 0; out_stall_pct = 0; end
				1: begin in_idle_pct = 52; out_stall_pct = 0; end
				2: begin in_idle_pct = 0; out_stall_pct = 52; end
				default: begin in_idle_pct = 23; out_stall_pct = 23; end
			endcase
			case (p)
				1, 5: send_pct = 85;
				2, 6: send_pct = 30;
				3: send_pct = 60;
				default: send_pct = 50;
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				put_item(random_item(send_pct));
		end

		wait_idle();
		if (sb.awaited_results.size() != 0)
			sb.report_mismatch("results never arrived");
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
